// ===== rtl/core/fpa_pkg.sv =====
// Package: opcodes, widths and the pipeline token type of the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;
    localparam int FRACTION_BITS = 8;
    localparam int DATA_W        = 32;
    localparam int DIV_W         = DATA_W + FRACTION_BITS;
    localparam int STAGES        = DIV_W;

    typedef enum logic [3:0] {
        OP_ADD          = 4'd0,
        OP_SUB          = 4'd1,
        OP_MUL          = 4'd2,
        OP_DIV          = 4'd3,
        OP_INC          = 4'd4,
        OP_DEC          = 4'd5,
        OP_MIN          = 4'd6,
        OP_MAX          = 4'd7,
        OP_INT_TO_FIXED = 4'd8,
        OP_FIXED_TO_INT = 4'd9
    } op_t;

    // One item travelling down the cell row.
    typedef struct packed {
        logic                valid;
        logic                is_div;
        logic                neg_q;
        logic [DIV_W-1:0]    rem;
        logic [DIV_W-1:0]    quo;
        logic [DATA_W-1:0]   divisor;
        logic [DATA_W-1:0]   result;
        logic                a_less;
        logic                a_equal;
        logic                a_greater;
        logic                divide_by_zero;
    } token_t;
endpackage

// ===== rtl/core/fpa_if.sv =====
// Interfaces: valid/ready channels for operation items and result items.
`timescale 1ns / 1ps
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
    modport source (output valid, result, a_less, a_equal, a_greater, divide_by_zero,
                    input ready);
    modport sink   (input valid, result, a_less, a_equal, a_greater, divide_by_zero,
                    output ready);
endinterface

// ===== rtl/core/fpa_front.sv =====
// Front stage: decodes an item, computes all non-divide results and seeds the divider.
`timescale 1ns / 1ps
module fpa_front
    import fpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [3:0]         func,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output token_t             tok
);
    token_t tok_reg;
    token_t tok_next;
    logic signed [63:0] prod;
    logic [DATA_W-1:0]  abs_a;
    logic [DATA_W-1:0]  abs_b;

    assign prod  = 64'(operand_a) * 64'(operand_b);
    assign abs_a = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : operand_a;
    assign abs_b = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : operand_b;

    always_comb
    begin
        tok_next                = '0;
        tok_next.valid          = in_valid;
        tok_next.a_less         = operand_a < operand_b;
        tok_next.a_equal        = operand_a == operand_b;
        tok_next.a_greater      = operand_a > operand_b;
        tok_next.rem            = '0;
        tok_next.quo            = {abs_a, FRACTION_BITS'(0)};
        tok_next.divisor        = abs_b;
        tok_next.neg_q          = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        case (func)
            OP_ADD:          tok_next.result = operand_a + operand_b;
            OP_SUB:          tok_next.result = operand_a - operand_b;
            OP_MUL:          tok_next.result = prod[FRACTION_BITS +: DATA_W];
            OP_DIV:
            begin
                tok_next.divide_by_zero = operand_b == '0;
                tok_next.is_div         = operand_b != '0;
            end
            OP_INC:          tok_next.result = operand_a + 32'sd1;
            OP_DEC:          tok_next.result = operand_a - 32'sd1;
            OP_MIN:          tok_next.result = (operand_a < operand_b) ? operand_a : operand_b;
            OP_MAX:          tok_next.result = (operand_a > operand_b) ? operand_a : operand_b;
            OP_INT_TO_FIXED: tok_next.result = operand_a <<< FRACTION_BITS;
            OP_FIXED_TO_INT: tok_next.result = operand_a >>> FRACTION_BITS;
            default:         tok_next.result = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (advance)
            tok_reg <= tok_next;
    end

    assign tok = tok_reg;
endmodule

// ===== rtl/core/fpa_cell.sv =====
// Divider cell: one restoring quotient bit per cell, passes the item on.
`timescale 1ns / 1ps
module fpa_cell
    import fpa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  token_t tok_in,
    output token_t tok_out
);
    token_t           tok_reg;
    token_t           tok_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   shifted;

    always_comb
    begin
        tok_next = tok_in;
        shifted  = {tok_in.rem, tok_in.quo[DIV_W-1]};
        trial    = shifted - (DIV_W+1)'(tok_in.divisor);
        if (tok_in.is_div)
        begin
            tok_next.quo = {tok_in.quo[DIV_W-2:0], !trial[DIV_W]};
            tok_next.rem = trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (advance)
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;
endmodule

// ===== rtl/core/fixed_point_alu.sv =====
// Top level: signed fixed-point ALU with a pipelined cell-chain divider.
//
//  channel | direction | payload
//  op_in   | sink      | func, operand_a, operand_b
//  res_out | source    | result, a_less, a_equal, a_greater, divide_by_zero
//
// Every item, divide or not, passes through the same stages in order:
// one front stage, one restoring-division cell per quotient bit, one output stage.
// One item enters per cycle unless the whole row stalls; it advances whenever the
// output register is empty or its result is taken in the same cycle.
// Reset clears the front and cell registers and the output valid bit.
`timescale 1ns / 1ps
module fixed_point_alu
    import fpa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    fpa_in_if.sink   op_in,
    fpa_out_if.source res_out
);
    token_t chain [STAGES+1];
    logic   advance;
    logic   out_valid_reg;
    logic [DATA_W-1:0] out_result_reg;
    logic   out_less_reg;
    logic   out_equal_reg;
    logic   out_greater_reg;
    logic   out_dz_reg;
    logic [DATA_W-1:0] quo_fix;
    token_t last;

    assign advance     = !out_valid_reg || res_out.ready;
    assign op_in.ready = advance;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (op_in.valid),
        .func      (op_in.func),
        .operand_a (op_in.operand_a),
        .operand_b (op_in.operand_b),
        .tok       (chain[0])
    );

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        fpa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign last    = chain[STAGES];
    assign quo_fix = last.neg_q ? DATA_W'(-last.quo) : last.quo[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg  <= last.is_div ? quo_fix : last.result;
            out_less_reg    <= last.a_less;
            out_equal_reg   <= last.a_equal;
            out_greater_reg <= last.a_greater;
            out_dz_reg      <= last.divide_by_zero;
        end
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.result         = out_result_reg;
    assign res_out.a_less         = out_less_reg;
    assign res_out.a_equal        = out_equal_reg;
    assign res_out.a_greater      = out_greater_reg;
    assign res_out.divide_by_zero = out_dz_reg;
endmodule
